/* hdl/adsr_eg_pkg.sv */
package adsr_eg_pkg;

    localparam int PHASE_FRACTION_BITS = 24;
    localparam int CURVE_TABLE_DEPTH   = 256;

    localparam int DEPTH_BITS = $clog2(CURVE_TABLE_DEPTH);
    localparam int PW         = PHASE_FRACTION_BITS + 1;
    localparam int IDX_W      = DEPTH_BITS + 1;
    localparam int NODE_W     = 20;
    localparam int CUBE_W     = 30;
    localparam int MAXS_W     = 24;
    localparam int DEN_W      = CUBE_W + MAXS_W;
    localparam int PROD_W     = NODE_W + PW + 1;
    localparam int ISUM_W     = PROD_W + 1;
    localparam int SUM_W      = 37;
    localparam int DIV_STEPS  = PHASE_FRACTION_BITS + 1;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [PW-1:0] PH_ONE      = PW'(1) << PHASE_FRACTION_BITS;
    localparam logic [PW-1:0] PH_STEP_MAX = PH_ONE + PW'(1);
    // first partial remainder of 2^(F+30) over a quotient of F+1 bits
    localparam logic [DEN_W-1:0] DIV_INIT = DEN_W'(1) << 29;

    localparam logic [2:0] STAGE_ATTACK  = 3'd0;
    localparam logic [2:0] STAGE_DECAY   = 3'd1;
    localparam logic [2:0] STAGE_SUSTAIN = 3'd2;
    localparam logic [2:0] STAGE_RELEASE = 3'd3;
    localparam logic [2:0] STAGE_STANDBY = 3'd4;

    localparam logic [1:0] MODE_ADSR    = 2'd0;
    localparam logic [1:0] MODE_ONESHOT = 2'd1;
    localparam logic [1:0] MODE_LOOP    = 2'd2;

    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_MAX_ATTACK  = 2'd1;
    localparam logic [1:0] REG_MAX_DECAY   = 2'd2;
    localparam logic [1:0] REG_MAX_RELEASE = 2'd3;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_PREP   = 4'd2;
    localparam logic [3:0] OP_MUL1   = 4'd3;
    localparam logic [3:0] OP_MUL2   = 4'd4;
    localparam logic [3:0] OP_MUL3   = 4'd5;
    localparam logic [3:0] OP_DIV    = 4'd6;
    localparam logic [3:0] OP_SHAPE  = 4'd7;
    localparam logic [3:0] OP_LEVEL  = 4'd8;
    localparam logic [3:0] OP_COMMIT = 4'd9;

    typedef struct packed {
        logic [3:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_skip;
    } dp_status_t;

    typedef logic signed [NODE_W-1:0] node_t;
    typedef node_t node_tab_t [0:CURVE_TABLE_DEPTH];

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 in Q16 by repeated squaring
    function automatic longint log2_q16(input longint x);
        int     e;
        longint y;
        longint res;
        e = 0;
        while ((x >> (e + 1)) != 0)
            e++;
        y = x << (30 - e);
        res = longint'(e) << 16;
        for (int i = 15; i >= 0; i--)
        begin
            y = (y * y) >>> 30;
            if (y >= (longint'(2) << 30))
            begin
                y = y >>> 1;
                res = res | (longint'(1) << i);
            end
        end
        return res;
    endfunction

    function automatic node_tab_t build_tab(input logic expo);
        node_tab_t   tab;
        logic [63:0] roots [0:15];
        logic [63:0] r;
        logic [63:0] v;
        longint      m;
        longint      n;
        longint      f;
        longint      val;
        // 2^(-2^(i-16)) in Q30, one per fraction bit
        r = 64'd1 << 29;
        for (int i = 15; i >= 0; i--)
        begin
            r = isqrt64(r << 30);
            roots[i] = r;
        end
        for (int k = 0; k <= CURVE_TABLE_DEPTH; k++)
        begin
            if (expo)
            begin
                m = 8 * (CURVE_TABLE_DEPTH - k);
                n = m / CURVE_TABLE_DEPTH;
                f = ((m % CURVE_TABLE_DEPTH) << 16) / CURVE_TABLE_DEPTH;
                v = 64'd1 << 30;
                for (int i = 15; i >= 0; i--)
                begin
                    if (((f >> i) & 1) != 0)
                        v = (v * roots[i]) >> 30;
                end
                val = longint'((v >> n) >> 15);
            end
            else if (k == 0)
                val = -262144;
            else
                val = 32768 + (log2_q16(longint'(k)) - log2_q16(CURVE_TABLE_DEPTH)) / 16;
            tab[k] = NODE_W'(val);
        end
        return tab;
    endfunction

    localparam node_tab_t EXP_TAB = build_tab(1'b1);
    localparam node_tab_t LOG_TAB = build_tab(1'b0);

endpackage

/* hdl/adsr_eg_sample_if.sv */
interface adsr_eg_sample_if;
    logic               valid;
    logic               ready;
    logic               gate;
    logic [14:0]        attack_time;
    logic signed [15:0] attack_curve;
    logic [14:0]        decay_time;
    logic signed [15:0] decay_curve;
    logic [14:0]        sustain_level;
    logic [14:0]        release_time;
    logic signed [15:0] release_curve;

    modport source (
        output valid, gate, attack_time, attack_curve, decay_time, decay_curve,
               sustain_level, release_time, release_curve,
        input  ready
    );

    modport sink (
        input  valid, gate, attack_time, attack_curve, decay_time, decay_curve,
               sustain_level, release_time, release_curve,
        output ready
    );
endinterface

/* hdl/adsr_eg_result_if.sv */
interface adsr_eg_result_if;
    logic        valid;
    logic        ready;
    logic [14:0] level;
    logic [2:0]  stage;

    modport source (
        output valid, level, stage,
        input  ready
    );

    modport sink (
        input  valid, level, stage,
        output ready
    );
endinterface

/* hdl/adsr_eg_ctrl.sv */
module adsr_eg_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    output logic                    result_valid,
    input  logic                    result_ready,
    output adsr_eg_pkg::dp_cmd_t    cmd,
    input  adsr_eg_pkg::dp_status_t status
);
    import adsr_eg_pkg::*;

    localparam logic [3:0] CS_IDLE   = 4'd0;
    localparam logic [3:0] CS_PREP   = 4'd1;
    localparam logic [3:0] CS_MUL1   = 4'd2;
    localparam logic [3:0] CS_MUL2   = 4'd3;
    localparam logic [3:0] CS_MUL3   = 4'd4;
    localparam logic [3:0] CS_DIV    = 4'd5;
    localparam logic [3:0] CS_SHAPE  = 4'd6;
    localparam logic [3:0] CS_LEVEL  = 4'd7;
    localparam logic [3:0] CS_COMMIT = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    assign sample_ready = (state_reg == CS_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NONE;
        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = CS_PREP;
                end
            end
            CS_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = CS_MUL1;
            end
            CS_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = CS_MUL2;
            end
            CS_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = CS_MUL3;
            end
            CS_MUL3:
            begin
                cmd.op     = OP_MUL3;
                cnt_next   = '0;
                state_next = CS_DIV;
            end
            CS_DIV:
            begin
                // step saturates: no quotient needed
                if (status.div_skip)
                    state_next = CS_SHAPE;
                else
                begin
                    cmd.op = OP_DIV;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        cnt_next   = '0;
                        state_next = CS_SHAPE;
                    end
                    else
                        cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            CS_SHAPE:
            begin
                cmd.op     = OP_SHAPE;
                state_next = CS_LEVEL;
            end
            CS_LEVEL:
            begin
                cmd.op     = OP_LEVEL;
                state_next = CS_COMMIT;
            end
            CS_COMMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.op         = OP_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> (state_reg == CS_PREP))
        else $error("accepted request did not start processing");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_COMMIT && (!out_valid_reg || result_ready))
        |=> (result_valid && state_reg == CS_IDLE))
        else $error("commit did not present a result");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider step count out of range");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_COMMIT && out_valid_reg && !result_ready)
        |=> (state_reg == CS_COMMIT))
        else $error("commit left while output still full");

endmodule

/* hdl/adsr_eg_datapath.sv */
module adsr_eg_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [1:0]              wr_index,
    input  logic [23:0]             wr_data,
    input  logic                    gate,
    input  logic [14:0]             attack_time,
    input  logic signed [15:0]      attack_curve,
    input  logic [14:0]             decay_time,
    input  logic signed [15:0]      decay_curve,
    input  logic [14:0]             sustain_level,
    input  logic [14:0]             release_time,
    input  logic signed [15:0]      release_curve,
    input  adsr_eg_pkg::dp_cmd_t    cmd,
    output adsr_eg_pkg::dp_status_t status,
    output logic [14:0]             level,
    output logic [2:0]              stage
);
    import adsr_eg_pkg::*;

    localparam int F = PHASE_FRACTION_BITS;
    localparam logic [PW+9:0] ZERO_LIM = (PW+10)'(990) << F;

    // state with reset
    logic [1:0]        mode_reg, mode_next;
    logic [MAXS_W-1:0] max_att_reg, max_att_next;
    logic [MAXS_W-1:0] max_dec_reg, max_dec_next;
    logic [MAXS_W-1:0] max_rel_reg, max_rel_next;
    logic [2:0]        stage_reg, stage_next;
    logic [PW-1:0]     phase_reg, phase_next;
    logic [14:0]       lba_reg, lba_next;
    logic [14:0]       lbr_reg, lbr_next;
    logic              gate_reg, gate_next;

    // working registers
    logic [14:0]              at_reg, at_next, dt_reg, dt_next, rt_reg, rt_next;
    logic [14:0]              sus_reg, sus_next;
    logic signed [15:0]       ac_reg, ac_next, dc_reg, dc_next, rc_reg, rc_next;
    logic [14:0]              t_reg, t_next;
    logic [MAXS_W-1:0]        maxs_reg, maxs_next;
    logic signed [15:0]       crv_reg, crv_next;
    logic [PW-1:0]            pp_reg, pp_next;
    logic                     zero_reg, zero_next;
    logic [29:0]              tt_reg, tt_next;
    logic [CUBE_W-1:0]        cube_reg, cube_next;
    logic signed [PROD_W-1:0] prod0_reg, prod0_next, prod1_reg, prod1_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic signed [NODE_W-1:0] cv_reg, cv_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [DEN_W-1:0]         rem_reg, rem_next;
    logic [PW-1:0]            quo_reg, quo_next;
    logic                     sat_reg, sat_next;
    logic [15:0]              shape_reg, shape_next;
    logic [PW-1:0]            inc_reg, inc_next;
    logic [14:0]              lvl_reg, lvl_next;
    logic [14:0]              level_reg, level_next;
    logic [2:0]               stage_out_reg, stage_out_next;

    // combinational helpers
    logic [IDX_W-1:0]         k_idx, k_nxt;
    logic [F-1:0]             frac_r;
    logic [PW-1:0]            one_m_r;
    node_t                    v0, v1;
    logic signed [ISUM_W-1:0] isum, imag;
    logic signed [ISUM_W-1:0] iquo;
    logic [15:0]              a_abs;
    logic [14:0]              a_w;
    logic [15:0]              lin;
    logic [44:0]              t3;
    logic [DEN_W:0]           rem2;
    logic [29:0]              sx;
    logic [16:0]              q0, r0, r1;
    logic [16:0]              qf;
    logic [30:0]              mprod;
    logic [16:0]              lsum;
    logic [PW:0]              np;
    logic                     ended;
    logic [PW-1:0]            ph_src;
    logic [PW+9:0]            ph_scaled;

    assign status.div_skip = sat_reg;
    assign level = level_reg;
    assign stage = stage_out_reg;

    always_comb
    begin
        mode_next      = mode_reg;
        max_att_next   = max_att_reg;
        max_dec_next   = max_dec_reg;
        max_rel_next   = max_rel_reg;
        stage_next     = stage_reg;
        phase_next     = phase_reg;
        lba_next       = lba_reg;
        lbr_next       = lbr_reg;
        gate_next      = gate_reg;
        at_next        = at_reg;
        dt_next        = dt_reg;
        rt_next        = rt_reg;
        sus_next       = sus_reg;
        ac_next        = ac_reg;
        dc_next        = dc_reg;
        rc_next        = rc_reg;
        t_next         = t_reg;
        maxs_next      = maxs_reg;
        crv_next       = crv_reg;
        pp_next        = pp_reg;
        zero_next      = zero_reg;
        tt_next        = tt_reg;
        cube_next      = cube_reg;
        prod0_next     = prod0_reg;
        prod1_next     = prod1_reg;
        den_next       = den_reg;
        cv_next        = cv_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        sat_next       = sat_reg;
        shape_next     = shape_reg;
        inc_next       = inc_reg;
        lvl_next       = lvl_reg;
        level_next     = level_reg;
        stage_out_next = stage_out_reg;

        k_idx     = pp_reg[PW-1 -: IDX_W];
        k_nxt     = (k_idx == IDX_W'(CURVE_TABLE_DEPTH)) ? k_idx : k_idx + IDX_W'(1);
        frac_r    = {pp_reg[F-DEPTH_BITS-1:0], {DEPTH_BITS{1'b0}}};
        one_m_r   = PH_ONE - {1'b0, frac_r};
        v0        = crv_reg[15] ? EXP_TAB[k_idx] : LOG_TAB[k_idx];
        v1        = crv_reg[15] ? EXP_TAB[k_nxt] : LOG_TAB[k_nxt];
        isum      = ISUM_W'(prod0_reg) + ISUM_W'(prod1_reg);
        imag      = isum[ISUM_W-1] ? -isum : isum;
        iquo      = imag >>> F;
        a_abs     = crv_reg[15] ? 16'(-crv_reg) : 16'(crv_reg);
        a_w       = a_abs[15] ? 15'h7fff : a_abs[14:0];
        lin       = pp_reg[PW-1:F-15];
        t3        = 45'(tt_reg) * 45'(t_reg);
        rem2      = {rem_reg, 1'b0};
        sx        = sum_reg[29:0];
        q0        = 17'(sx[29:15]);
        r0        = 17'(sx[14:0]) + q0;
        r1        = r0;
        qf        = q0;
        mprod     = '0;
        lsum      = '0;
        np        = {1'b0, phase_reg} + {1'b0, inc_reg};
        ended     = (np > {1'b0, PH_ONE});
        ph_src    = (stage_reg == STAGE_ATTACK) ? phase_reg : PH_ONE - phase_reg;
        ph_scaled = (PW+10)'(phase_reg) * (PW+10)'(1000);

        if (wr_en)
        begin
            case (wr_index)
                REG_MODE:        mode_next    = wr_data[1:0];
                REG_MAX_ATTACK:  max_att_next = wr_data;
                REG_MAX_DECAY:   max_dec_next = wr_data;
                REG_MAX_RELEASE: max_rel_next = wr_data;
                default:         mode_next    = mode_reg;
            endcase
        end

        case (cmd.op)
            OP_LOAD:
            begin
                at_next  = attack_time;
                dt_next  = decay_time;
                rt_next  = release_time;
                sus_next = sustain_level;
                ac_next  = attack_curve;
                dc_next  = decay_curve;
                rc_next  = release_curve;
                // gate edges restart attack or enter release
                if (!gate_reg && gate)
                begin
                    stage_next = STAGE_ATTACK;
                    phase_next = '0;
                end
                else if (gate_reg && !gate && stage_reg != STAGE_RELEASE)
                begin
                    stage_next = STAGE_RELEASE;
                    phase_next = '0;
                end
                gate_next = gate;
            end
            OP_PREP:
            begin
                pp_next   = ph_src;
                zero_next = 1'b0;
                case (stage_reg)
                    STAGE_ATTACK:
                    begin
                        t_next    = at_reg;
                        maxs_next = max_att_reg;
                        crv_next  = ac_reg;
                    end
                    STAGE_DECAY:
                    begin
                        t_next    = dt_reg;
                        maxs_next = max_dec_reg;
                        crv_next  = dc_reg;
                        zero_next = !dc_reg[15] && (ph_scaled > ZERO_LIM);
                    end
                    default:
                    begin
                        t_next    = rt_reg;
                        maxs_next = max_rel_reg;
                        crv_next  = rc_reg;
                        zero_next = !rc_reg[15] && (ph_scaled > ZERO_LIM);
                    end
                endcase
                tt_next = 30'(ph_src[0] & 1'b0) + 30'(t_next) * 30'(t_next);
            end
            OP_MUL1:
            begin
                cube_next  = t3[44:15];
                prod0_next = PROD_W'(v0) * PROD_W'($signed({1'b0, one_m_r}));
                prod1_next = PROD_W'(v1) * PROD_W'($signed({2'b0, frac_r}));
            end
            OP_MUL2:
            begin
                den_next = DEN_W'(cube_reg) * DEN_W'(maxs_reg);
                cv_next  = isum[ISUM_W-1] ? NODE_W'(-iquo) : NODE_W'(iquo);
            end
            OP_MUL3:
            begin
                sum_next = SUM_W'($signed({1'b0, a_w})) * SUM_W'(cv_reg)
                         + SUM_W'($signed({1'b0, 15'h7fff - a_w}))
                         * SUM_W'($signed({1'b0, lin}));
                rem_next = DIV_INIT;
                quo_next = '0;
                sat_next = (den_reg <= DIV_INIT);
            end
            OP_DIV:
            begin
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_next = DEN_W'(rem2 - {1'b0, den_reg});
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[DEN_W-1:0];
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
            end
            OP_SHAPE:
            begin
                // divide by 32767 from x>>15 with two corrections
                if (r0 >= 17'd32767)
                begin
                    r1 = r0 - 17'd32767;
                    qf = q0 + 17'd1;
                end
                if (r1 >= 17'd32767)
                    qf = qf + 17'd1;
                if (sum_reg[SUM_W-1] || zero_reg)
                    shape_next = '0;
                else if (qf > 17'd32768)
                    shape_next = 16'd32768;
                else
                    shape_next = qf[15:0];
                if (sat_reg || quo_reg > PH_STEP_MAX)
                    inc_next = PH_STEP_MAX;
                else
                    inc_next = quo_reg;
            end
            OP_LEVEL:
            begin
                case (stage_reg)
                    STAGE_ATTACK:
                    begin
                        mprod = 31'(shape_reg) * 31'(15'h7fff - lba_reg);
                        lsum  = 17'(lba_reg) + 17'(mprod[30:15]);
                    end
                    STAGE_DECAY:
                    begin
                        mprod = 31'(shape_reg) * 31'(15'h7fff - sus_reg);
                        lsum  = 17'(sus_reg) + 17'(mprod[30:15]);
                    end
                    STAGE_SUSTAIN:
                        lsum = 17'(sus_reg);
                    STAGE_RELEASE:
                    begin
                        mprod = 31'(shape_reg) * 31'(lbr_reg);
                        lsum  = 17'(mprod[30:15]);
                    end
                    default:
                        lsum = '0;
                endcase
                lvl_next = (lsum > 17'h7fff) ? 15'h7fff : lsum[14:0];
            end
            OP_COMMIT:
            begin
                case (stage_reg)
                    STAGE_ATTACK:
                    begin
                        phase_next = ended ? '0 : np[PW-1:0];
                        if (ended)
                            stage_next = STAGE_DECAY;
                    end
                    STAGE_DECAY:
                    begin
                        phase_next = ended ? '0 : np[PW-1:0];
                        if (ended)
                        begin
                            if (mode_reg == MODE_ADSR)
                                stage_next = STAGE_SUSTAIN;
                            else
                                stage_next = STAGE_RELEASE;
                        end
                    end
                    STAGE_RELEASE:
                    begin
                        phase_next = ended ? '0 : np[PW-1:0];
                        if (ended)
                        begin
                            if (mode_reg == MODE_LOOP)
                            begin
                                stage_next = STAGE_ATTACK;
                                lba_next   = '0;
                            end
                            else
                                stage_next = STAGE_STANDBY;
                        end
                    end
                    STAGE_STANDBY:
                    begin
                        if (mode_reg == MODE_LOOP)
                        begin
                            stage_next = STAGE_ATTACK;
                            lba_next   = '0;
                        end
                    end
                    default:
                        stage_next = stage_reg;
                endcase
                // every mode but ADSR (one-shot, loop and modes above loop) falls through to release
                if (stage_next != STAGE_RELEASE || stage_reg == STAGE_DECAY)
                    lbr_next = lvl_reg;
                if (stage_next != STAGE_ATTACK)
                    lba_next = lvl_reg;
                level_next     = lvl_reg;
                stage_out_next = stage_next;
            end
            default:
            begin
                sat_next = sat_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ADSR;
            max_att_reg <= MAXS_W'(44100);
            max_dec_reg <= MAXS_W'(44100);
            max_rel_reg <= MAXS_W'(44100);
            stage_reg   <= STAGE_STANDBY;
            phase_reg   <= '0;
            lba_reg     <= '0;
            lbr_reg     <= '0;
            gate_reg    <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            max_att_reg <= max_att_next;
            max_dec_reg <= max_dec_next;
            max_rel_reg <= max_rel_next;
            stage_reg   <= stage_next;
            phase_reg   <= phase_next;
            lba_reg     <= lba_next;
            lbr_reg     <= lbr_next;
            gate_reg    <= gate_next;
            sat_reg     <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_reg        <= at_next;
        dt_reg        <= dt_next;
        rt_reg        <= rt_next;
        sus_reg       <= sus_next;
        ac_reg        <= ac_next;
        dc_reg        <= dc_next;
        rc_reg        <= rc_next;
        t_reg         <= t_next;
        maxs_reg      <= maxs_next;
        crv_reg       <= crv_next;
        pp_reg        <= pp_next;
        zero_reg      <= zero_next;
        tt_reg        <= tt_next;
        cube_reg      <= cube_next;
        prod0_reg     <= prod0_next;
        prod1_reg     <= prod1_next;
        den_reg       <= den_next;
        cv_reg        <= cv_next;
        sum_reg       <= sum_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        shape_reg     <= shape_next;
        inc_reg       <= inc_next;
        lvl_reg       <= lvl_next;
        level_reg     <= level_next;
        stage_out_reg <= stage_out_next;
    end

endmodule

/* hdl/adsr_envelope_generator.sv */
// ADSR envelope generator: one level per accepted sample request. A request
// goes through operand select, three multiply steps, a restoring divider (one
// quotient bit per cycle, for 2^54 / ((time^3 >> 15) * max_samples)), shape,
// level and commit; the divider is skipped when the phase step saturates, and
// commit waits while the output register still holds an untaken result.
// A new request is taken while the previous result waits in the output
// register. Config writes go through wr_en / wr_index / wr_data and
// must only happen while no request is in flight.
module adsr_envelope_generator (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [1:0]              wr_index,
    input  logic [23:0]             wr_data,
    adsr_eg_sample_if.sink          sample,
    adsr_eg_result_if.source        result
);
    import adsr_eg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    adsr_eg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .status       (status)
    );

    adsr_eg_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .gate          (sample.gate),
        .attack_time   (sample.attack_time),
        .attack_curve  (sample.attack_curve),
        .decay_time    (sample.decay_time),
        .decay_curve   (sample.decay_curve),
        .sustain_level (sample.sustain_level),
        .release_time  (sample.release_time),
        .release_curve (sample.release_curve),
        .cmd           (cmd),
        .status        (status),
        .level         (result.level),
        .stage         (result.stage)
    );

endmodule
